// ===== rtl/fhfd_pkg.sv =====
// fhfd_pkg: shared constants for the fsk half-period frame demodulator
// register indexes, field widths, input kind codes and register reset values
// no dependencies
`default_nettype none

package fhfd_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // register widths
  localparam int MODULUS_W   = 17;
  localparam int THRESHOLD_W = 16;
  localparam int TICK_W      = 16;

  // result field widths
  localparam int FRAME_BYTE_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_MODULUS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_ODD       = 3'd4;

  // register reset values
  localparam logic [MODULUS_W-1:0]   RST_CAPTURE_MODULUS  = 17'd50000;
  localparam logic [THRESHOLD_W-1:0] RST_START_THRESHOLD  = 16'd17000;
  localparam logic [THRESHOLD_W-1:0] RST_BIT_THRESHOLD    = 16'd14000;
  localparam logic [TICK_W-1:0]      RST_BIT_PERIOD_TICKS = 16'd833;
  localparam logic                   RST_PARITY_ODD       = 1'b1;

  // input word kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

endpackage : fhfd_pkg

`default_nettype wire

// ===== rtl/fsk_halfperiod_frame_demod_core.sv =====
// fsk_halfperiod_frame_demod_core: edge-timestamp fsk demodulator with uart-like framing
// depends on fhfd_pkg
// results are registered in the output register, or in the skid while out_stall is high
// throughput: one input word per cycle; the whole edge/tick update sits between the
//   state registers and the result register, and a two-entry output (register + skid)
//   lets input continue while a result waits; in_stall rises only when both are full
// reset: synchronous active-low rst_n clears framing state and loads register defaults
`default_nettype none

module fsk_halfperiod_frame_demod_core #(
  parameter int CAPTURE_WIDTH = 16,
  parameter int DATA_BITS     = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_wr_en,
  input  wire logic [fhfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [fhfd_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_kind,
  input  wire logic [CAPTURE_WIDTH-1:0]             in_capture_value,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [fhfd_pkg::FRAME_BYTE_W-1:0]         out_frame_byte,
  output logic                                      out_frame_bad,
  output logic                                      out_error_seen
);

  localparam int DIFF_W = (CAPTURE_WIDTH > fhfd_pkg::MODULUS_W) ?
                          CAPTURE_WIDTH : fhfd_pkg::MODULUS_W;
  localparam int BITS_W = $clog2(DATA_BITS + 1);
  localparam int IDX_W  = $clog2(DATA_BITS);
  localparam logic [CAPTURE_WIDTH-1:0] CAP_MAX = {CAPTURE_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_READ  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  typedef struct packed {
    logic [fhfd_pkg::FRAME_BYTE_W-1:0] frame_byte;
    logic                              frame_bad;
    logic                              error_seen;
  } result_t;

  // configuration registers
  logic [fhfd_pkg::MODULUS_W-1:0]   capture_modulus_r;
  logic [fhfd_pkg::THRESHOLD_W-1:0] start_threshold_r;
  logic [fhfd_pkg::THRESHOLD_W-1:0] bit_threshold_r;
  logic [fhfd_pkg::TICK_W-1:0]      bit_period_ticks_r;
  logic                             parity_odd_r;

  // framing state
  phase_t                    phase_r, phase_nxt;
  logic [CAPTURE_WIDTH-1:0]  prev_capture_r, prev_capture_nxt;
  logic [CAPTURE_WIDTH-1:0]  half_period_r, half_period_nxt;
  logic                      wait_edges_r, wait_edges_nxt;
  logic [BITS_W-1:0]         bits_taken_r, bits_taken_nxt;
  logic [DATA_BITS-1:0]      shift_byte_r, shift_byte_nxt;
  logic                      parity_bit_r, parity_bit_nxt;
  logic [fhfd_pkg::TICK_W-1:0] tick_count_r, tick_count_nxt;
  logic                      timer_running_r, timer_running_nxt;
  logic                      error_sticky_r, error_sticky_nxt;

  // output register and skid stage
  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;

  logic    in_accept;
  logic    res_valid;
  result_t res_data;

  // interval and decode helpers
  logic [DIFF_W-1:0]         fwd_diff;
  logic [DIFF_W-1:0]         back_diff;
  logic [DIFF_W-1:0]         modulus_ext;
  logic [DIFF_W-1:0]         wrap_diff;
  logic [DIFF_W-1:0]         raw_diff;
  logic [CAPTURE_WIDTH-1:0]  interval;
  logic [fhfd_pkg::TICK_W-1:0] tick_inc;
  logic                      sample_bit;
  logic [IDX_W-1:0]          bit_idx;
  logic                      parity_ok;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;

  // wrap-corrected half-period, saturated to the capture width
  always_comb begin
    fwd_diff    = DIFF_W'(in_capture_value - prev_capture_r);
    back_diff   = DIFF_W'(prev_capture_r - in_capture_value);
    modulus_ext = DIFF_W'(capture_modulus_r);
    wrap_diff   = (modulus_ext > back_diff) ? (modulus_ext - back_diff) : '0;
    raw_diff    = (in_capture_value >= prev_capture_r) ? fwd_diff : wrap_diff;
    interval    = (raw_diff > DIFF_W'(CAP_MAX)) ? CAP_MAX : CAPTURE_WIDTH'(raw_diff);
  end

  // bit sample, shift position and parity check
  assign tick_inc   = tick_count_r + 1'b1;
  assign sample_bit = DIFF_W'(half_period_r) > DIFF_W'(bit_threshold_r);
  assign bit_idx    = IDX_W'(DATA_BITS - 1) - bits_taken_r[IDX_W-1:0];
  assign parity_ok  = ((^shift_byte_r) ^ parity_bit_r) == parity_odd_r;

  // next state for one accepted word
  always_comb begin
    phase_nxt         = phase_r;
    prev_capture_nxt  = prev_capture_r;
    half_period_nxt   = half_period_r;
    wait_edges_nxt    = wait_edges_r;
    bits_taken_nxt    = bits_taken_r;
    shift_byte_nxt    = shift_byte_r;
    parity_bit_nxt    = parity_bit_r;
    tick_count_nxt    = tick_count_r;
    timer_running_nxt = timer_running_r;
    error_sticky_nxt  = error_sticky_r;
    res_valid         = 1'b0;
    res_data          = '0;

    if (in_accept) begin
      if (in_kind == fhfd_pkg::KIND_EDGE) begin
        // edge: new half-period and start detection
        half_period_nxt  = interval;
        prev_capture_nxt = in_capture_value;
        unique case (phase_r)
          PH_IDLE: begin
            if (DIFF_W'(interval) < DIFF_W'(start_threshold_r)) begin
              phase_nxt = PH_WAIT;
            end
          end
          PH_WAIT: begin
            if (wait_edges_r) begin
              phase_nxt         = PH_READ;
              timer_running_nxt = 1'b1;
              tick_count_nxt    = '0;
              wait_edges_nxt    = 1'b0;
            end else begin
              wait_edges_nxt = 1'b1;
            end
          end
          PH_READ, PH_CHECK: begin
          end
          default: begin
          end
        endcase
      end else if (timer_running_r) begin
        // tick: advance the bit timer
        if (tick_inc >= bit_period_ticks_r) begin
          tick_count_nxt = '0;
          unique case (phase_r)
            PH_READ: begin
              if (bits_taken_r >= BITS_W'(DATA_BITS)) begin
                parity_bit_nxt = sample_bit;
                bits_taken_nxt = '0;
                phase_nxt      = PH_CHECK;
              end else begin
                shift_byte_nxt[bit_idx] = shift_byte_r[bit_idx] | sample_bit;
                bits_taken_nxt          = bits_taken_r + 1'b1;
              end
            end
            PH_CHECK: begin
              timer_running_nxt = 1'b0;
              res_valid         = 1'b1;
              if (parity_ok) begin
                res_data.frame_byte = fhfd_pkg::FRAME_BYTE_W'(shift_byte_r);
                res_data.frame_bad  = 1'b0;
                res_data.error_seen = error_sticky_r;
              end else begin
                error_sticky_nxt    = 1'b1;
                res_data.frame_byte = '0;
                res_data.frame_bad  = 1'b1;
                res_data.error_seen = 1'b1;
              end
              shift_byte_nxt = '0;
              parity_bit_nxt = 1'b0;
              phase_nxt      = PH_IDLE;
            end
            PH_IDLE, PH_WAIT: begin
              // timer fired outside a frame: drop it
              timer_running_nxt = 1'b0;
              shift_byte_nxt    = '0;
              parity_bit_nxt    = 1'b0;
              phase_nxt         = PH_IDLE;
            end
            default: begin
            end
          endcase
        end else begin
          tick_count_nxt = tick_inc;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_modulus_r  <= fhfd_pkg::RST_CAPTURE_MODULUS;
      start_threshold_r  <= fhfd_pkg::RST_START_THRESHOLD;
      bit_threshold_r    <= fhfd_pkg::RST_BIT_THRESHOLD;
      bit_period_ticks_r <= fhfd_pkg::RST_BIT_PERIOD_TICKS;
      parity_odd_r       <= fhfd_pkg::RST_PARITY_ODD;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fhfd_pkg::REG_CAPTURE_MODULUS:
          capture_modulus_r <= cfg_data[fhfd_pkg::MODULUS_W-1:0];
        fhfd_pkg::REG_START_THRESHOLD:
          start_threshold_r <= cfg_data[fhfd_pkg::THRESHOLD_W-1:0];
        fhfd_pkg::REG_BIT_THRESHOLD:
          bit_threshold_r <= cfg_data[fhfd_pkg::THRESHOLD_W-1:0];
        fhfd_pkg::REG_BIT_PERIOD_TICKS:
          bit_period_ticks_r <= cfg_data[fhfd_pkg::TICK_W-1:0];
        fhfd_pkg::REG_PARITY_ODD:
          parity_odd_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // framing state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      prev_capture_r  <= '0;
      half_period_r   <= '0;
      wait_edges_r    <= 1'b0;
      bits_taken_r    <= '0;
      shift_byte_r    <= '0;
      parity_bit_r    <= 1'b0;
      tick_count_r    <= '0;
      timer_running_r <= 1'b0;
      error_sticky_r  <= 1'b0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      prev_capture_r  <= prev_capture_nxt;
      half_period_r   <= half_period_nxt;
      wait_edges_r    <= wait_edges_nxt;
      bits_taken_r    <= bits_taken_nxt;
      shift_byte_r    <= shift_byte_nxt;
      parity_bit_r    <= parity_bit_nxt;
      tick_count_r    <= tick_count_nxt;
      timer_running_r <= timer_running_nxt;
      error_sticky_r  <= error_sticky_nxt;
      // output register with skid stage
      if (skid_valid_r) begin
        // no word accepted; drain skid when the output moves
        if (!out_stall) begin
          out_valid_r  <= 1'b1;
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end
      end else if (!out_valid_r || !out_stall) begin
        out_valid_r <= res_valid;
        if (res_valid) begin
          out_data_r <= res_data;
        end
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= res_data;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_data_r.frame_byte;
  assign out_frame_bad  = out_data_r.frame_bad;
  assign out_error_seen = out_data_r.error_seen;

endmodule : fsk_halfperiod_frame_demod_core

`default_nettype wire

// ===== rtl/fhfd_checker.sv =====
// fhfd_checker: port-level checks for the fsk frame demodulator and its bind
// depends on fhfd_pkg and fsk_halfperiod_frame_demod_core
`default_nettype none

module fhfd_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [fhfd_pkg::FRAME_BYTE_W-1:0] out_frame_byte,
  input wire logic                             out_frame_bad,
  input wire logic                             out_error_seen
);

  logic seen_r;

  // remember any delivered word that reported a parity failure
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_error_seen) begin
      seen_r <= 1'b1;
    end
  end

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte) &&
      $stable(out_frame_bad) && $stable(out_error_seen))
    else $error("result word changed while stalled");

  // a rejected frame carries a zero byte
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_bad |-> out_frame_byte == '0)
    else $error("rejected frame with non-zero byte");

  // a rejected frame sets the sticky flag in the same word
  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_bad |-> out_error_seen)
    else $error("parity failure without error flag");

  // the error flag never clears once reported
  a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r |-> out_error_seen)
    else $error("error flag cleared after being reported");

endmodule : fhfd_checker

bind fsk_halfperiod_frame_demod_core fhfd_checker u_fhfd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_frame_byte (out_frame_byte),
  .out_frame_bad  (out_frame_bad),
  .out_error_seen (out_error_seen)
);

`default_nettype wire
